>>> rtl/flask_pkg.sv
// shared types and constants for the four-level ask demodulator
`default_nettype none

package flask_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS     = 16;
    localparam int MAG_BITS        = SAMPLE_BITS;
    localparam int SYM_LENGTH_BITS = 12;

    // divide by six as multiply by reciprocal, exact for values below 2**17
    localparam int              DIV6_SHIFT = 18;
    localparam logic [17:0]     DIV6_MUL   = 18'd43691;

    // symbol levels, lowest amplitude first
    localparam logic [1:0] SYM_LEVEL0 = 2'd0;
    localparam logic [1:0] SYM_LEVEL1 = 2'd1;
    localparam logic [1:0] SYM_LEVEL2 = 2'd2;
    localparam logic [1:0] SYM_LEVEL3 = 2'd3;

    // demodulator phases
    typedef enum logic [2:0] {
        PH_ZERO1 = 3'd0,
        PH_TONE  = 3'd1,
        PH_ZERO2 = 3'd2,
        PH_SKIP  = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    // input transaction
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          new_stream;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [1:0]                 symbol;
        logic [SYM_LENGTH_BITS-1:0] symbol_length;
    } t_out;

    // core result toward the output register
    typedef struct packed {
        logic emit;
        t_out data;
    } t_core_res;

endpackage

`default_nettype wire

>>> rtl/flask_in_stage.sv
// input register stage holding one accepted sample transaction
`default_nettype none

module flask_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire flask_pkg::t_in i_data,
    output logic               o_item_valid,
    output flask_pkg::t_in     o_item,
    input  wire logic          i_take
);
    import flask_pkg::*;

    logic r_valid;
    t_in  r_data;

    // hold while the core cannot take the stored transaction
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_data;

endmodule

`default_nettype wire

>>> rtl/flask_core.sv
// preamble sync, reference tracking and symbol slicing state machine
`default_nettype none

module flask_core #(
    parameter int MAX_SYMBOL_SAMPLES = 4095
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire flask_pkg::t_in i_item,
    input  wire logic           i_advance,
    output flask_pkg::t_core_res o_res
);
    import flask_pkg::*;

    localparam int              CW       = $clog2(MAX_SYMBOL_SAMPLES + 1);
    localparam int              SW       = CW + 2;
    localparam int              DW       = CW + 3;
    localparam int              MUL_W    = MAG_BITS + DIV6_SHIFT;
    localparam logic [CW-1:0]   CNT_MAX  = CW'(MAX_SYMBOL_SAMPLES);

    // state registers
    t_phase              r_phase;
    logic [CW-1:0]       r_fz, r_tone, r_sz, r_spd, r_wc;
    logic                r_pz;
    logic [SW-1:0]       r_skip;
    logic [MAG_BITS-1:0] r_ref, r_wp, r_t1;

    // effective state after an optional stream restart
    t_phase              s_phase;
    logic [CW-1:0]       s_fz, s_tone, s_sz, s_spd, s_wc;
    logic                s_pz;
    logic [SW-1:0]       s_skip;
    logic [MAG_BITS-1:0] s_ref, s_wp;

    // next state
    t_phase              n_phase;
    logic [CW-1:0]       n_fz, n_tone, n_sz, n_spd, n_wc;
    logic                n_pz;
    logic [SW-1:0]       n_skip;
    logic [MAG_BITS-1:0] n_ref, n_wp, n_t1;

    logic [MAG_BITS-1:0] raw, mag;
    logic                is_zero;
    logic [CW:0]         tone_p1;
    logic                len_match;
    logic [CW-1:0]       sync_spd;
    logic signed [DW-1:0] skip_full;
    logic [SW-1:0]       sync_skip;
    logic [MUL_W-1:0]    div_prod;
    logic [MAG_BITS+2:0] thr1, thr3, thr5, wp_ext;
    logic [CW-1:0]       wc_inc;
    logic [MAG_BITS-1:0] wp_max;
    logic [CW+SYM_LENGTH_BITS-1:0] len_ext;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v >= CNT_MAX) ? CNT_MAX : v + CW'(1);
    endfunction

    // sample magnitude, most negative value maps to its unsigned magnitude
    assign raw     = i_item.sample;
    assign mag     = raw[MAG_BITS-1] ? (~raw + MAG_BITS'(1)) : raw;
    assign is_zero = (mag == '0);

    // restart clears everything and begins with the first zero run search
    always_comb begin
        if (i_item.new_stream) begin
            s_phase = PH_ZERO1;
            s_fz    = '0;
            s_tone  = '0;
            s_sz    = '0;
            s_pz    = 1'b0;
            s_spd   = '0;
            s_skip  = '0;
            s_ref   = '0;
            s_wc    = '0;
            s_wp    = '0;
        end else begin
            s_phase = r_phase;
            s_fz    = r_fz;
            s_tone  = r_tone;
            s_sz    = r_sz;
            s_pz    = r_pz;
            s_spd   = r_spd;
            s_skip  = r_skip;
            s_ref   = r_ref;
            s_wc    = r_wc;
            s_wp    = r_wp;
        end
    end

    // symbol length and skip count from the three run lengths
    assign tone_p1   = {1'b0, s_tone} + (CW+1)'(1);
    assign len_match = (s_fz == s_sz) && ({1'b0, s_fz} == tone_p1);
    assign sync_spd  = (s_fz == '0) ? CW'(1) : (len_match ? s_fz - CW'(1) : s_fz);
    assign skip_full = $signed({sync_spd, 2'b00} | {DW{1'b0}})
                     - $signed(DW'(s_fz)) - $signed(DW'(s_tone)) - $signed(DW'(s_sz));
    assign sync_skip = skip_full[DW-1] ? '0 : skip_full[SW-1:0];

    // window update and slicing thresholds
    assign wc_inc = sat_inc(s_wc);
    assign wp_max = (mag > s_wp) ? mag : s_wp;
    assign wp_ext = (MAG_BITS+3)'(wp_max);
    assign thr1   = (MAG_BITS+3)'(r_t1);
    assign thr3   = thr1 + {thr1[MAG_BITS+1:0], 1'b0};
    assign thr5   = thr1 + {thr1[MAG_BITS:0], 2'b00};
    assign len_ext = {{SYM_LENGTH_BITS{1'b0}}, s_spd};

    // next state and result
    always_comb begin
        n_phase = s_phase;
        n_fz    = s_fz;
        n_tone  = s_tone;
        n_sz    = s_sz;
        n_pz    = s_pz;
        n_spd   = s_spd;
        n_skip  = s_skip;
        n_ref   = s_ref;
        n_wc    = s_wc;
        n_wp    = s_wp;
        o_res   = '0;
        o_res.data.symbol_length = len_ext[SYM_LENGTH_BITS-1:0];
        case (s_phase)
            PH_TONE: begin
                if (is_zero && s_pz) begin
                    n_sz    = CW'(2);
                    n_phase = PH_ZERO2;
                end else begin
                    n_tone = sat_inc(s_tone);
                    n_pz   = is_zero;
                end
            end
            PH_ZERO2: begin
                if (is_zero) begin
                    n_sz = sat_inc(s_sz);
                end else begin
                    n_spd   = sync_spd;
                    n_skip  = sync_skip;
                    n_ref   = '0;
                    n_wc    = '0;
                    n_wp    = '0;
                    n_phase = (sync_skip == '0) ? PH_DATA : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_ref  = (mag > s_ref) ? mag : s_ref;
                n_skip = (s_skip != '0) ? s_skip - SW'(1) : s_skip;
                if (n_skip == '0) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_wp = wp_max;
                n_wc = wc_inc;
                if (wc_inc >= s_spd) begin
                    o_res.emit = 1'b1;
                    if (wp_ext < thr1) begin
                        o_res.data.symbol = SYM_LEVEL0;
                    end else if (wp_ext < thr3) begin
                        o_res.data.symbol = SYM_LEVEL1;
                    end else if (wp_ext < thr5) begin
                        o_res.data.symbol = SYM_LEVEL2;
                    end else begin
                        o_res.data.symbol = SYM_LEVEL3;
                    end
                    n_wc = '0;
                    n_wp = '0;
                end
            end
            default: begin
                n_phase = PH_ZERO1;
                if (is_zero) begin
                    n_fz = sat_inc(s_fz);
                end else begin
                    n_tone  = CW'(1);
                    n_pz    = 1'b0;
                    n_phase = PH_TONE;
                end
            end
        endcase
    end

    // reference divided by six, kept ready for the data windows
    assign div_prod = MUL_W'(n_ref) * MUL_W'(DIV6_MUL);
    assign n_t1     = div_prod[DIV6_SHIFT +: MAG_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ZERO1;
            r_fz    <= '0;
            r_tone  <= '0;
            r_sz    <= '0;
            r_pz    <= 1'b0;
            r_spd   <= '0;
            r_skip  <= '0;
            r_ref   <= '0;
            r_wc    <= '0;
            r_wp    <= '0;
            r_t1    <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_fz    <= n_fz;
            r_tone  <= n_tone;
            r_sz    <= n_sz;
            r_pz    <= n_pz;
            r_spd   <= n_spd;
            r_skip  <= n_skip;
            r_ref   <= n_ref;
            r_wc    <= n_wc;
            r_wp    <= n_wp;
            r_t1    <= n_t1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/flask_out_stage.sv
// output register holding one symbol transaction until taken
`default_nettype none

module flask_out_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire flask_pkg::t_out i_data,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output flask_pkg::t_out      o_data
);
    import flask_pkg::*;

    logic r_valid;
    t_out r_data;

    // room when empty or when the current transaction leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> rtl/four_level_ask_demodulator.sv
// top level of the four-level ask demodulator
// Usage:
//   Input channel (i_valid, o_stall, i_in) carries one signed audio sample per
//   transaction; new_stream set restarts the sync search with that sample.
//   Output channel (o_valid, i_stall, o_out) carries one 2-bit symbol and the
//   samples per symbol found from the preamble, once per complete data window.
// Path: a sample accepted into the input register is processed from there; the
//   state registers and, for a symbol, the output register load together, and
//   the symbol is offered from then on until it is taken.
// Throughput: one sample per cycle while no symbol waits on a stalled output;
//   the state update is a single pass through compares, counters and one
//   constant multiply between the input register and the state registers.
// Reset: synchronous, active low; both channels empty, phase back to the
//   first zero run search, all counters and the reference cleared.
// Stall: a held output blocks only a sample that would produce a symbol;
//   samples that produce nothing keep flowing, and the input register then
//   raises o_stall until the output is taken.
`default_nettype none

module four_level_ask_demodulator #(
    parameter int MAX_SYMBOL_SAMPLES = 4095
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire flask_pkg::t_in  i_in,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output flask_pkg::t_out      o_out
);
    import flask_pkg::*;

    logic      item_valid;
    t_in       item;
    t_core_res res;
    logic      out_free;
    logic      core_fire;

    // a sample moves on unless its symbol finds the output register full and stalled
    assign core_fire = item_valid && (!res.emit || out_free);

    flask_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (core_fire)
    );

    flask_core #(
        .MAX_SYMBOL_SAMPLES (MAX_SYMBOL_SAMPLES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_advance (core_fire),
        .o_res     (res)
    );

    flask_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_fire && res.emit),
        .i_data  (res.data),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/flask_checker.sv
// port-level checks for the four-level ask demodulator and their binding
`default_nettype none

module flask_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_valid,
    input wire logic            o_stall,
    input wire flask_pkg::t_in  i_in,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire flask_pkg::t_out o_out
);
    import flask_pkg::*;

    // a held symbol transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("output transaction changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // input backpressure only comes from a stalled full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // a stream restart sample never produces a symbol
    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_valid && !o_stall && i_in.new_stream) ##1 !o_valid) |=> !o_valid)
        else $error("symbol produced by a stream restart sample");

endmodule

bind four_level_ask_demodulator flask_checker u_flask_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

`default_nettype wire

>>> dv/tb_four_level_ask_demodulator.sv
// self-checking testbench for the four-level ask demodulator
`timescale 1ns / 100ps

module tb_four_level_ask_demodulator;
    import flask_pkg::*;

    localparam int RUN_MAX       = 4095;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int IDLE_PCT      = 31;
    localparam int HOLD_AT       = 25;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 20;

    // one row of the directed table; want is only meaningful when has_want is set
    typedef struct packed {
        logic signed [15:0] smp;
        logic               ns;
        logic               has_want;
        logic [1:0]         sym;
        logic [11:0]        len;
    } t_dir_row;

    // one input transaction, with an optional hand-written expected symbol
    typedef struct {
        t_in  item;
        bit   has_want;
        t_out want;
    } t_demod_stim;

    // sync on a 2-sample symbol, full-scale reference, a window at each level,
    // then a stream with no leading zeros: zero length and negative skip
    localparam t_dir_row DIRECTED [27] = '{
        '{16'sd0,      1'b1, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd5,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{-16'sd1,     1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd32767,  1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sh8000,   1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b1, SYM_LEVEL0, 12'd2},
        '{16'sd32767,  1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd1,      1'b0, 1'b1, SYM_LEVEL3, 12'd2},
        '{16'sd10000,  1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{-16'sd3,     1'b0, 1'b1, SYM_LEVEL1, 12'd2},
        '{-16'sd20000, 1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b1, SYM_LEVEL2, 12'd2},
        '{16'sh8000,   1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd5,      1'b0, 1'b1, SYM_LEVEL3, 12'd2},
        '{16'sd123,    1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd77,     1'b1, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd3,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{-16'sd4,     1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{-16'sd9,     1'b0, 1'b0, SYM_LEVEL0, 12'd0},
        '{16'sd0,      1'b0, 1'b1, SYM_LEVEL3, 12'd1},
        '{16'sh8000,   1'b0, 1'b1, SYM_LEVEL3, 12'd1}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_in    = '0;
    logic o_stall;
    logic o_valid;
    t_out o_out;

    t_demod_stim sample_q[$];
    t_out        pending_symbols[$];
    int          n_samples_in = 0;
    int          n_errors     = 0;
    int          cycle_no     = 0;
    int unsigned n_taken      = 0;
    int unsigned hold_left    = 0;
    bit          held         = 1'b0;
    logic        calm;

    // demodulator state mirror
    t_phase      dm_phase;
    logic [11:0] dm_zrun1, dm_trun, dm_zrun2, dm_sym_len, dm_win_cnt;
    logic        dm_prev_zero;
    logic [13:0] dm_skip;
    logic [16:0] dm_ref, dm_win_pk;

    four_level_ask_demodulator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always #4 i_clk = ~i_clk;

    // cycle count, and a window in which neither side idles
    always @(posedge i_clk) cycle_no <= cycle_no + 1;
    assign calm = (cycle_no >= 600) && (cycle_no < 1400);

    function automatic logic [11:0] sat_count(logic [11:0] v);
        return (v >= RUN_MAX) ? 12'(RUN_MAX) : v + 12'd1;
    endfunction

    function automatic void clear_demod_state();
        dm_phase     = PH_ZERO1;
        dm_zrun1     = '0;
        dm_trun      = '0;
        dm_zrun2     = '0;
        dm_prev_zero = 1'b0;
        dm_sym_len   = '0;
        dm_skip      = '0;
        dm_ref       = '0;
        dm_win_cnt   = '0;
        dm_win_pk    = '0;
    endfunction

    // advance the mirror by one sample; emit is set when a window completes
    task automatic predict_symbol(input t_in x, output bit emit, output t_out res);
        int smp, mag, l0, l1, l2, spd, skip, t1;
        smp  = $signed(x.sample);
        mag  = (smp < 0) ? -smp : smp;
        emit = 1'b0;
        res  = '0;
        if (x.new_stream) clear_demod_state();
        case (dm_phase)
            PH_TONE: begin
                if (mag == 0 && dm_prev_zero) begin
                    dm_zrun2 = 12'd2;
                    dm_phase = PH_ZERO2;
                end else begin
                    dm_trun      = sat_count(dm_trun);
                    dm_prev_zero = (mag == 0);
                end
            end
            PH_ZERO2: begin
                if (mag == 0) begin
                    dm_zrun2 = sat_count(dm_zrun2);
                end else begin
                    // runs locked: derive symbol length and rest of preamble
                    l0   = int'(dm_zrun1);
                    l1   = int'(dm_trun) - 1;
                    l2   = int'(dm_zrun2);
                    spd  = (l0 == l2 && l0 == l1 + 2) ? l0 - 1 : l0;
                    if (spd < 1) spd = 1;
                    if (spd > RUN_MAX) spd = RUN_MAX;
                    skip = 4 * spd - (l0 + l1 + l2) - 1;
                    if (skip < 0) skip = 0;
                    dm_sym_len = 12'(spd);
                    dm_skip    = 14'(skip);
                    dm_ref     = '0;
                    dm_win_cnt = '0;
                    dm_win_pk  = '0;
                    dm_phase   = (skip == 0) ? PH_DATA : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (mag > int'(dm_ref)) dm_ref = 17'(mag);
                if (dm_skip != 0) dm_skip = dm_skip - 14'd1;
                if (dm_skip == 0) dm_phase = PH_DATA;
            end
            PH_DATA: begin
                if (mag > int'(dm_win_pk)) dm_win_pk = 17'(mag);
                dm_win_cnt = sat_count(dm_win_cnt);
                if (dm_win_cnt >= dm_sym_len) begin
                    t1 = int'(dm_ref) / 6;
                    if (int'(dm_win_pk) < t1)          res.symbol = SYM_LEVEL0;
                    else if (int'(dm_win_pk) < 3 * t1) res.symbol = SYM_LEVEL1;
                    else if (int'(dm_win_pk) < 5 * t1) res.symbol = SYM_LEVEL2;
                    else                               res.symbol = SYM_LEVEL3;
                    res.symbol_length = dm_sym_len;
                    emit       = 1'b1;
                    dm_win_cnt = '0;
                    dm_win_pk  = '0;
                end
            end
            default: begin
                dm_phase = PH_ZERO1;
                if (mag == 0) begin
                    dm_zrun1 = sat_count(dm_zrun1);
                end else begin
                    dm_trun      = 12'd1;
                    dm_prev_zero = 1'b0;
                    dm_phase     = PH_TONE;
                end
            end
        endcase
    endtask

    task automatic add_sample(input int s, input bit ns);
        t_demod_stim rec;
        rec.item.sample     = 16'(s);
        rec.item.new_stream = ns;
        rec.has_want        = 1'b0;
        rec.want            = '0;
        sample_q.insert(sample_q.size(), rec);
    endtask

    // sample of the given magnitude and random sign; full negative scale has no twin
    function automatic int mag_sample(int m);
        if (m == 0) return 0;
        if (m >= 32768) return -32768;
        return $urandom_range(1) ? m : -m;
    endfunction

    // whole stream: zero run, tone, closing zeros, skipped preamble, data windows
    task automatic gen_frame(input int l0, input int n_tone, input int extra,
                             input int n_win, input int amp);
        int  k, j, hit, pk, tone_run, l0s, l1, l2, spd, skip, ref_amp, t1;
        bit  ns, prev_zero;
        ns        = 1'b1;
        prev_zero = 1'b0;
        for (k = 0; k < l0; k++) begin
            add_sample(0, ns);
            ns = 1'b0;
        end
        // tone may hold lone zeros, never two in a row, and ends nonzero
        for (k = 0; k < n_tone; k++) begin
            if (k == 0 || k == n_tone - 1 || prev_zero || $urandom_range(99) >= 15) begin
                add_sample(mag_sample($urandom_range(1, 32768)), ns);
                prev_zero = 1'b0;
            end else begin
                add_sample(0, ns);
                prev_zero = 1'b1;
            end
            ns = 1'b0;
        end
        for (k = 0; k < extra + 2; k++) add_sample(0, 1'b0);
        add_sample(mag_sample($urandom_range(1, 32768)), 1'b0);

        // window size as the block should see it, so data lands on window edges
        l0s      = (l0 > RUN_MAX) ? RUN_MAX : l0;
        tone_run = (n_tone + 1 > RUN_MAX) ? RUN_MAX : n_tone + 1;
        l1       = tone_run - 1;
        l2       = (extra + 2 > RUN_MAX) ? RUN_MAX : extra + 2;
        spd      = (l0s == l2 && l0s == l1 + 2) ? l0s - 1 : l0s;
        if (spd < 1) spd = 1;
        if (spd > RUN_MAX) spd = RUN_MAX;
        skip     = 4 * spd - (l0s + l1 + l2) - 1;
        if (skip < 0) skip = 0;

        // rest of preamble, peaking exactly at amp
        hit = (skip > 0) ? $urandom_range(0, skip - 1) : 0;
        for (k = 0; k < skip; k++)
            add_sample(mag_sample((k == hit) ? amp : $urandom_range(0, amp)), 1'b0);
        ref_amp = (skip > 0) ? amp : 0;
        t1      = ref_amp / 6;

        // data windows with peaks on and around the decision levels
        for (j = 0; j < n_win; j++) begin
            case ($urandom_range(0, 7))
                0: pk = t1 - 1;
                1: pk = t1;
                2: pk = 3 * t1 - 1;
                3: pk = 3 * t1;
                4: pk = 5 * t1 - 1;
                5: pk = 5 * t1;
                6: pk = $urandom_range(0, 32768);
                default: pk = 0;
            endcase
            if (pk < 0) pk = 0;
            if (pk > 32768) pk = 32768;
            hit = $urandom_range(0, spd - 1);
            for (k = 0; k < spd; k++)
                add_sample(mag_sample((k == hit) ? pk : $urandom_range(0, pk)), 1'b0);
        end
        // trailing partial window
        if (spd > 1 && spd < 100 && $urandom_range(99) < 30)
            repeat ($urandom_range(1, spd - 1))
                add_sample(mag_sample($urandom_range(0, 32768)), 1'b0);
    endtask

    // prediction on every accepted sample, comparison on every accepted symbol
    always @(posedge i_clk) begin : scoreboard
        bit          emit;
        t_out        got, want;
        t_demod_stim rec;
        if (i_rst_n && i_valid && !o_stall) begin
            rec = sample_q[n_samples_in];
            n_samples_in++;
            predict_symbol(i_in, emit, got);
            if (rec.has_want) pending_symbols.insert(pending_symbols.size(), rec.want);
            else if (emit) pending_symbols.insert(pending_symbols.size(), got);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_symbols.size() == 0) begin
                $error("unexpected symbol transaction: symbol %0d, symbol_length %0d",
                       o_out.symbol, o_out.symbol_length);
                n_errors++;
            end else begin
                want = pending_symbols.pop_front();
                if (o_out.symbol !== want.symbol) begin
                    $error("symbol: expected %0d, got %0d", want.symbol, o_out.symbol);
                    n_errors++;
                end
                if (o_out.symbol_length !== want.symbol_length) begin
                    $error("symbol_length: expected %0d, got %0d",
                           want.symbol_length, o_out.symbol_length);
                    n_errors++;
                end
            end
        end
    end

    // output side: random stalls, one long hold-off to back the block up
    always @(posedge i_clk) begin : receiver
        if (i_rst_n && o_valid && !i_stall) n_taken++;
        if (!held && n_taken == HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // give up when no transaction moves on either side for too long
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_run = 0;
            else idle_run++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int          idx, sel, l0, amp, start, cut;
        t_demod_stim rec;
        clear_demod_state();

        // directed table
        foreach (DIRECTED[r]) begin
            rec.item.sample     = DIRECTED[r].smp;
            rec.item.new_stream = DIRECTED[r].ns;
            rec.has_want        = DIRECTED[r].has_want;
            rec.want.symbol        = DIRECTED[r].sym;
            rec.want.symbol_length = DIRECTED[r].len;
            sample_q.insert(sample_q.size(), rec);
        end

        // random streams: mostly well formed, some noise, some cut short
        while (sample_q.size() < $size(DIRECTED) + RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            case ($urandom_range(3))
                0: amp = 32768;
                1: amp = 32767;
                2: amp = $urandom_range(1, 32767);
                default: amp = $urandom_range(6, 60);
            endcase
            if (sel < 75) begin
                if ($urandom_range(3) == 0) begin
                    // run lengths that take the minus-one correction
                    l0 = $urandom_range(3, 10);
                    gen_frame(l0, l0 - 2, l0 - 2, $urandom_range(1, 6), amp);
                end else begin
                    gen_frame($urandom_range(0, 12), $urandom_range(1, 12),
                              $urandom_range(0, 6), $urandom_range(1, 6), amp);
                end
            end else if (sel < 88) begin
                repeat ($urandom_range(10, 40))
                    add_sample(($urandom_range(99) < 35) ? 0 : $signed(16'($urandom)),
                               $urandom_range(99) < 3);
            end else begin
                start = sample_q.size();
                gen_frame($urandom_range(0, 8), $urandom_range(1, 10),
                          $urandom_range(0, 4), 1, amp);
                cut = $urandom_range(1, sample_q.size() - start - 1);
                repeat (cut) sample_q.delete(sample_q.size() - 1);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // input side: random gaps between transactions, payload held while stalled
        for (idx = 0; idx < sample_q.size(); idx++) begin
            while (!calm && $urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_in    <= sample_q[idx].item;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;

        while (n_samples_in < sample_q.size() || pending_symbols.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/flask_pkg.sv
rtl/flask_in_stage.sv
rtl/flask_core.sv
rtl/flask_out_stage.sv
rtl/four_level_ask_demodulator.sv
rtl/flask_checker.sv
dv/tb_four_level_ask_demodulator.sv
